// ----- hdl/cbxo_pkg.sv -----
// Shared types, constants and helpers for the coordinate BCD XOR-chain obfuscator.
package cbxo_pkg;

  localparam int LAT_W         = 25;
  localparam int LON_W         = 26;
  localparam int BIN_W         = 26;   // common magnitude width of both coordinates
  localparam int BCD_W         = 32;   // eight decimal digits
  localparam int DD_BITS       = 2;    // binary bits consumed per conversion cycle
  localparam int DD_STEPS      = BIN_W / DD_BITS;
  localparam int DD_CNT_W      = $clog2(DD_STEPS);
  localparam int KEY_W         = 8;
  localparam int CHAR_W        = 7;
  localparam int CHARS         = 16;
  localparam int CHAR_IDX_W    = $clog2(CHARS);
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [BIN_W-1:0]  NEG_MAG_MAX = BIN_W'(9999999);
  localparam logic [7:0]        BYTE_MASK   = 8'hEA;
  localparam logic [3:0]        NEG_NIBBLE  = 4'hF;
  localparam logic [CHAR_W-1:0] ERR_CHAR    = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_A_M10 = 7'd55;   // 'A' minus ten

  typedef struct packed {
    logic        err;
    logic [63:0] bytes;   // masked bytes, first byte in the top eight bits
  } cbxo_entry_t;

  // Add three to every BCD digit of five or more (one double-dabble correction).
  function automatic logic [BCD_W-1:0] dd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] r;
    r = bcd;
    for (int d = 0; d < BCD_W / 4; d++) begin
      if (bcd[d*4 +: 4] >= 4'd5) begin
        r[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  // Two double-dabble steps, the higher incoming bit first.
  function automatic logic [BCD_W-1:0] dd_step2(input logic [BCD_W-1:0] bcd,
                                                 input logic [1:0] bits);
    logic [BCD_W-1:0] s1;
    logic [BCD_W-1:0] a1;
    logic [BCD_W-1:0] a2;
    a1 = dd_adjust(bcd);
    s1 = {a1[BCD_W-2:0], bits[1]};
    a2 = dd_adjust(s1);
    return {a2[BCD_W-2:0], bits[0]};
  endfunction

  function automatic logic [CHAR_W-1:0] nibble_ascii(input logic [3:0] n);
    if (n <= 4'd9) begin
      return ASCII_ZERO + CHAR_W'(n);
    end
    return ASCII_A_M10 + CHAR_W'(n);
  endfunction

endpackage

// ----- hdl/cbxo_front.sv -----
// Front end: take a coordinate pair, check range and convert both magnitudes to BCD.
module cbxo_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cbxo_pkg::LAT_W-1:0] lat_scaled,
  input  logic [cbxo_pkg::LON_W-1:0] lon_scaled,
  output logic                       q_valid,
  input  logic                       q_ready,
  output cbxo_pkg::cbxo_entry_t      q_data
);

  typedef enum logic [1:0] {IDLE, CONV, PUSH} state_t;

  state_t                             state;
  logic [cbxo_pkg::DD_CNT_W-1:0]      cnt;
  logic [cbxo_pkg::BIN_W-1:0]         lat_bin;
  logic [cbxo_pkg::BIN_W-1:0]         lon_bin;
  logic [cbxo_pkg::BCD_W-1:0]         lat_bcd;
  logic [cbxo_pkg::BCD_W-1:0]         lon_bcd;
  logic                               lat_neg;
  logic                               lon_neg;
  logic                               err;

  logic                               accept;
  logic                               lat_neg_in;
  logic                               lon_neg_in;
  logic [cbxo_pkg::LAT_W-1:0]         lat_mag;
  logic [cbxo_pkg::LON_W-1:0]         lon_mag;
  logic [cbxo_pkg::BIN_W-1:0]         lat_mag_x;
  logic [cbxo_pkg::BIN_W-1:0]         lon_mag_x;
  logic                               err_in;
  logic [cbxo_pkg::BCD_W-1:0]         lat_word;
  logic [cbxo_pkg::BCD_W-1:0]         lon_word;

  assign in_ready = (state == IDLE) || ((state == PUSH) && q_ready);
  assign accept   = in_valid && in_ready;

  assign lat_neg_in = lat_scaled[cbxo_pkg::LAT_W-1];
  assign lon_neg_in = lon_scaled[cbxo_pkg::LON_W-1];
  assign lat_mag    = lat_neg_in ? (~lat_scaled + 1'b1) : lat_scaled;
  assign lon_mag    = lon_neg_in ? (~lon_scaled + 1'b1) : lon_scaled;
  assign lat_mag_x  = cbxo_pkg::BIN_W'(lat_mag);
  assign lon_mag_x  = cbxo_pkg::BIN_W'(lon_mag);
  assign err_in     = (lat_neg_in && (lat_mag_x > cbxo_pkg::NEG_MAG_MAX)) ||
                      (lon_neg_in && (lon_mag_x > cbxo_pkg::NEG_MAG_MAX));

  // Negative values carry the sign nibble over the top digit.
  assign lat_word = lat_neg ? {cbxo_pkg::NEG_NIBBLE, lat_bcd[cbxo_pkg::BCD_W-5:0]} : lat_bcd;
  assign lon_word = lon_neg ? {cbxo_pkg::NEG_NIBBLE, lon_bcd[cbxo_pkg::BCD_W-5:0]} : lon_bcd;

  assign q_valid      = (state == PUSH);
  assign q_data.err   = err;
  assign q_data.bytes = {lat_word, lon_word} ^ {8{cbxo_pkg::BYTE_MASK}};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            state <= CONV;
          end
        end
        CONV: begin
          lat_bcd <= cbxo_pkg::dd_step2(lat_bcd, lat_bin[cbxo_pkg::BIN_W-1 -: 2]);
          lon_bcd <= cbxo_pkg::dd_step2(lon_bcd, lon_bin[cbxo_pkg::BIN_W-1 -: 2]);
          lat_bin <= {lat_bin[cbxo_pkg::BIN_W-3:0], 2'b00};
          lon_bin <= {lon_bin[cbxo_pkg::BIN_W-3:0], 2'b00};
          cnt     <= cnt + 1'b1;
          if (cnt == cbxo_pkg::DD_CNT_W'(cbxo_pkg::DD_STEPS - 1)) begin
            state <= PUSH;
          end
        end
        PUSH: begin
          if (accept) begin
            state <= CONV;
          end else if (q_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (accept) begin
        cnt     <= '0;
        lat_bin <= lat_mag_x;
        lon_bin <= lon_mag_x;
        lat_bcd <= '0;
        lon_bcd <= '0;
        lat_neg <= lat_neg_in;
        lon_neg <= lon_neg_in;
        err     <= err_in;
      end
    end
  end

endmodule

// ----- hdl/cbxo_queue.sv -----
// Small register queue between the converter and the character serialiser.
module cbxo_queue #(
  parameter int DEPTH = cbxo_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  cbxo_pkg::cbxo_entry_t wr_data,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output cbxo_pkg::cbxo_entry_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cbxo_pkg::cbxo_entry_t slots [DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;
  logic                  push;
  logic                  pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= wr_data;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/cbxo_back.sv -----
// Back end: run the XOR chain over the eight bytes and emit one hex character a cycle while out_ready allows.
module cbxo_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        point_key_we,
  input  logic [cbxo_pkg::KEY_W-1:0]  point_key,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  cbxo_pkg::cbxo_entry_t       q_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cbxo_pkg::CHAR_W-1:0] hex_char,
  output logic                        last_char,
  output logic                        range_error
);

  logic [cbxo_pkg::KEY_W-1:0]      key;
  cbxo_pkg::cbxo_entry_t           ent;
  logic                            active;
  logic [cbxo_pkg::CHAR_IDX_W-1:0] idx;
  logic [7:0]                      prev;

  logic                            slot_free;
  logic                            take;
  logic                            is_last;
  logic                            finish;
  logic [2:0]                      byte_idx;
  logic [7:0]                      cur_byte;
  logic [7:0]                      chain;
  logic [3:0]                      nib;

  assign slot_free = !out_valid || out_ready;
  assign take      = active && slot_free;
  assign is_last   = ent.err || (idx == cbxo_pkg::CHAR_IDX_W'(cbxo_pkg::CHARS - 1));
  assign finish    = take && is_last;
  assign q_ready   = !active || finish;

  assign byte_idx = 3'd7 - idx[cbxo_pkg::CHAR_IDX_W-1:1];
  assign cur_byte = ent.bytes[{byte_idx, 3'b000} +: 8];
  assign chain    = cur_byte ^ prev;
  assign nib      = idx[0] ? chain[3:0] : chain[7:4];

  always_ff @(posedge clk) begin
    if (rst) begin
      key       <= '0;
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (point_key_we) begin
        key <= point_key;
      end
      if (q_valid && q_ready) begin
        ent    <= q_data;
        active <= 1'b1;
        idx    <= '0;
        prev   <= key;
      end else if (finish) begin
        active <= 1'b0;
      end else if (take) begin
        idx <= idx + 1'b1;
        if (idx[0]) begin
          prev <= chain;
        end
      end
      if (take) begin
        out_valid   <= 1'b1;
        hex_char    <= ent.err ? cbxo_pkg::ERR_CHAR : cbxo_pkg::nibble_ascii(nib);
        last_char   <= is_last;
        range_error <= ent.err;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/coordinate_bcd_xor_chain_obfuscator_top.sv -----
// Top level of the coordinate BCD XOR-chain obfuscator.
// Each request carries one latitude/longitude pair in 1e-5 degree units. Both
// magnitudes are converted to eight BCD digits by a double-dabble unit that
// takes two binary bits a cycle, a negative value gets the F sign nibble over
// its top digit, the sixteen nibbles are masked with 0xEA and queued, then a
// serialiser runs the XOR chain seeded by point_key and emits one uppercase
// hex ASCII character per cycle while out_ready does not hold it back, high
// nibble first, flagging the sixteenth with last_char. A negative magnitude
// above 9999999 in either coordinate yields a single '0' result with
// last_char and range_error set. The serialiser sets the sustained rate;
// the converter works on the next request while the serialiser drains the
// previous one. Write point_key only while the block is idle; it is sampled
// when a request reaches the serialiser.
module coordinate_bcd_xor_chain_obfuscator_top #(
  parameter int QUEUE_DEPTH = cbxo_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        point_key_we,
  input  logic [cbxo_pkg::KEY_W-1:0]  point_key,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cbxo_pkg::LAT_W-1:0]  lat_scaled,
  input  logic [cbxo_pkg::LON_W-1:0]  lon_scaled,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cbxo_pkg::CHAR_W-1:0] hex_char,
  output logic                        last_char,
  output logic                        range_error
);

  // Converted requests travelling from front to back.
  logic                  fq_valid;
  logic                  fq_ready;
  cbxo_pkg::cbxo_entry_t fq_data;
  logic                  qb_valid;
  logic                  qb_ready;
  cbxo_pkg::cbxo_entry_t qb_data;

  // Accept, range-check and convert to BCD.
  cbxo_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .lat_scaled (lat_scaled),
    .lon_scaled (lon_scaled),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_data     (fq_data)
  );

  // Hold converted requests so each side stalls on its own.
  cbxo_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  // Chain-encrypt and serialise into hex characters.
  cbxo_back u_back (
    .clk          (clk),
    .rst          (rst),
    .point_key_we (point_key_we),
    .point_key    (point_key),
    .q_valid      (qb_valid),
    .q_ready      (qb_ready),
    .q_data       (qb_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hex_char     (hex_char),
    .last_char    (last_char),
    .range_error  (range_error)
  );

endmodule
